// ===== rtl/sped_pkg.sv =====
package sped_pkg;

	localparam int MAX_RECORD  = 4096;
	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;

	localparam int ADDR_W  = $clog2(MAX_RECORD);
	localparam int CNT_W   = ADDR_W + 1;
	localparam int RING_W  = $clog2(MAX_WINDOW);
	localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W   = SAMPLE_BITS + RING_W + 1;
	localparam int VAL_W   = 24;
	localparam int POS_W   = 21;
	localparam int LEN_W   = 13;
	localparam int WCFG_W  = 7;
	localparam int DVD_W   = 49;
	localparam int DVS_W   = 29;
	localparam int PEAK_W  = POS_W + VAL_W + 1 + ADDR_W;
	localparam int CROSS_W = POS_W + 1 + ADDR_W;

	typedef enum logic [1:0] {
		OP_PUSH       = 2'd0,
		OP_READ_PEAK  = 2'd1,
		OP_READ_CROSS = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_SUMMARY = 2'd0,
		KIND_PEAK    = 2'd1,
		KIND_CROSS   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CFG_RECORD_LENGTH = 2'd0,
		CFG_SMOOTHING_ON  = 2'd1,
		CFG_WINDOW_LENGTH = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SUM,
		ST_SDIV,
		ST_STORE,
		ST_MID,
		ST_SW_RD,
		ST_SW_WT,
		ST_X_CHK,
		ST_X_DIV,
		ST_P_CHK,
		ST_P_MUL,
		ST_P_DIV1,
		ST_P_START2,
		ST_P_DIV2,
		ST_NEXT,
		ST_SUMMARY,
		ST_RD,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		op_t                            op;
		logic signed [SAMPLE_BITS-1:0]  sample;
		logic [ADDR_W-1:0]              index;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  index;
		logic [LEN_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		kind_t                    kind;
		logic                     entry_valid;
		logic [POS_W-1:0]         position;
		logic signed [VAL_W-1:0]  level;
		logic                     polarity;
		logic [ADDR_W-1:0]        sample_position;
		logic [CNT_W-1:0]         peak_total;
		logic [CNT_W-1:0]         crossing_total;
		logic signed [VAL_W-1:0]  midpoint;
	} res_t;

	function automatic logic signed [VAL_W-1:0] sat24(input logic signed [VAL_W+1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 26'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -26'sd8388608)
			r = 24'sh800000;
		else
			r = v[VAL_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/sped_ram.sv =====
module sped_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sped_div.sv =====
module sped_div import sped_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0] rem_sh;
	logic [DVS_W:0] rem_sub;
	logic           ge;

	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			cnt_q  <= CW'(DVD_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			// one quotient bit per cycle, restoring form
			rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== rtl/sped_front.sv =====
module sped_front import sped_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [ADDR_W-1:0]             entry_index,
	output logic                          q_valid,
	output item_t                         q_item,
	input  logic                          q_pop
);

	item_t      mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       push;
	op_t        op;

	assign op       = op_t'(operation);
	assign in_stall = cnt_q == 2'd2;
	// unused code is taken and dropped here
	assign push     = in_valid && !in_stall && (op != OP_NONE);
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (q_pop)
				rp_q <= !rp_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= '{op: op, sample: sample, index: entry_index};
	end

endmodule

// ===== rtl/sped_back.sv =====
module sped_back import sped_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg_wr,
	input  logic    q_valid,
	input  item_t   q_item,
	output logic    q_pop,
	output logic    out_valid,
	input  logic    out_stall,
	output res_t    out_res
);

	state_t state_q, state_d;
	item_t  item_q;

	logic [LEN_W-1:0]  rec_len_q;
	logic              smooth_q;
	logic [WCFG_W-1:0] win_q;

	logic [ADDR_W-1:0]       c_q;
	logic [WIN_W-1:0]        n_q, k_q;
	logic                    pend_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [VAL_W-1:0] v_q, max_q, min_q, mid_q;
	logic [CNT_W-1:0]        nrec_q, pcnt_q, xcnt_q;
	logic [ADDR_W-1:0]       j_q;
	logic signed [VAL_W-1:0] ya_q, yb_q, yc_q;
	logic                    xpol_q, ppol_q, rdv_q, div_neg_q;
	logic signed [VAL_W:0]   d_q;
	logic signed [VAL_W+1:0] den_q;
	logic [DVD_W-1:0]        dd_q;
	logic [POS_W-1:0]        ppos_q;
	res_t                    res_q, res_d;
	logic                    out_valid_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// effective record length and window
	logic [LEN_W-1:0]  len_eff, w1, w2, n13;
	logic [WCFG_W-1:0] w0;
	logic [CNT_W-1:0]  c_inc;
	always_comb begin
		if (rec_len_q < LEN_W'(2))
			len_eff = LEN_W'(2);
		else if (rec_len_q > LEN_W'(MAX_RECORD))
			len_eff = LEN_W'(MAX_RECORD);
		else
			len_eff = rec_len_q;
		w0 = (win_q == '0) ? WCFG_W'(1) : win_q;
		w1 = (LEN_W'(w0) > len_eff) ? len_eff : LEN_W'(w0);
		w2 = (w1 > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : w1;
		c_inc = CNT_W'(c_q) + CNT_W'(1);
		n13 = (LEN_W'(c_inc) < w2) ? LEN_W'(c_inc) : w2;
	end

	// memories
	logic                   ring_we, ring_re;
	logic [RING_W-1:0]      ring_ra;
	logic [SAMPLE_BITS-1:0] ring_rd;
	logic                   st_we, st_re;
	logic [VAL_W-1:0]       st_rd;
	logic                   pt_we, pt_re, xt_we, xt_re;
	logic [PEAK_W-1:0]      pt_wd, pt_rd;
	logic [CROSS_W-1:0]     xt_wd, xt_rd;

	sped_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
		.clk(clk), .we(ring_we), .waddr(c_q[RING_W-1:0]), .wdata(item_q.sample),
		.re(ring_re), .raddr(ring_ra), .rdata(ring_rd)
	);

	sped_ram #(.WIDTH(VAL_W), .DEPTH(MAX_RECORD)) u_store (
		.clk(clk), .we(st_we), .waddr(c_q), .wdata(v_q),
		.re(st_re), .raddr(j_q), .rdata(st_rd)
	);

	sped_ram #(.WIDTH(PEAK_W), .DEPTH(MAX_RECORD)) u_peak_tbl (
		.clk(clk), .we(pt_we), .waddr(pcnt_q[ADDR_W-1:0]), .wdata(pt_wd),
		.re(pt_re), .raddr(item_q.index), .rdata(pt_rd)
	);

	sped_ram #(.WIDTH(CROSS_W), .DEPTH(MAX_RECORD)) u_cross_tbl (
		.clk(clk), .we(xt_we), .waddr(xcnt_q[ADDR_W-1:0]), .wdata(xt_wd),
		.re(xt_re), .raddr(item_q.index), .rdata(xt_rd)
	);

	// shared divider
	logic             div_start, div_done, div_neg;
	logic [DVD_W-1:0] div_dvd, div_q, qs;
	logic [DVS_W-1:0] div_dvs;

	sped_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_q)
	);

	assign qs = div_neg_q ? (~div_q + DVD_W'(1)) : div_q;

	// detection terms
	logic signed [VAL_W:0]   x_num, x_den, d_now;
	logic signed [VAL_W+1:0] den_now, lev;
	logic [VAL_W:0]          x_num_m, x_den_m, d_mag;
	logic [VAL_W+1:0]        den_mag;
	logic [SUM_W-1:0]        sum_mag;
	logic                    rising, falling, is_max, is_min;
	logic [ADDR_W-1:0]       jm1;
	logic [POS_W-1:0]        base_pos;
	logic signed [VAL_W:0]   mid_sum;
	logic                    rd_hit;

	always_comb begin
		x_num   = (VAL_W+1)'(mid_q) - (VAL_W+1)'(yb_q);
		x_den   = (VAL_W+1)'(yc_q) - (VAL_W+1)'(yb_q);
		x_num_m = x_num[VAL_W] ? (VAL_W+1)'(-x_num) : (VAL_W+1)'(x_num);
		x_den_m = x_den[VAL_W] ? (VAL_W+1)'(-x_den) : (VAL_W+1)'(x_den);
		rising  = (yb_q < mid_q) && (yc_q >= mid_q);
		falling = (yb_q > mid_q) && (yc_q <= mid_q);
		is_max  = (yb_q > ya_q) && (yb_q > yc_q);
		is_min  = (yb_q < ya_q) && (yb_q < yc_q);
		d_now   = (VAL_W+1)'(ya_q) - (VAL_W+1)'(yc_q);
		den_now = (VAL_W+2)'(ya_q) + (VAL_W+2)'(yc_q) - ((VAL_W+2)'(yb_q) <<< 1);
		d_mag   = d_q[VAL_W] ? (VAL_W+1)'(-d_q) : (VAL_W+1)'(d_q);
		den_mag = den_q[VAL_W+1] ? (VAL_W+2)'(-den_q) : (VAL_W+2)'(den_q);
		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		lev     = (VAL_W+2)'(yb_q) - $signed(qs[VAL_W+1:0]);
		jm1     = j_q - ADDR_W'(1);
		base_pos = {1'b0, jm1, 8'b0};
		mid_sum = (VAL_W+1)'(max_q) + (VAL_W+1)'(min_q);
		rd_hit  = (item_q.op == OP_READ_PEAK) ? (CNT_W'(item_q.index) < pcnt_q)
		                                      : (CNT_W'(item_q.index) < xcnt_q);
	end

	assign pt_wd = {ppos_q, sat24(lev), ppol_q, jm1};
	assign xt_wd = {base_pos + qs[POS_W-1:0], xpol_q, jm1};

	// result transaction to load
	always_comb begin
		res_d = '0;
		if (state_q == ST_SUMMARY) begin
			res_d.kind           = KIND_SUMMARY;
			res_d.entry_valid    = 1'b1;
			res_d.peak_total     = pcnt_q;
			res_d.crossing_total = xcnt_q;
			res_d.midpoint       = mid_q;
		end else if (item_q.op == OP_READ_PEAK) begin
			res_d.kind = KIND_PEAK;
			if (rdv_q) begin
				res_d.entry_valid     = 1'b1;
				res_d.position        = pt_rd[PEAK_W-1 -: POS_W];
				res_d.level           = $signed(pt_rd[ADDR_W+1 +: VAL_W]);
				res_d.polarity        = pt_rd[ADDR_W];
				res_d.sample_position = pt_rd[ADDR_W-1:0];
			end
		end else begin
			res_d.kind = KIND_CROSS;
			if (rdv_q) begin
				res_d.entry_valid     = 1'b1;
				res_d.position        = xt_rd[CROSS_W-1 -: POS_W];
				res_d.polarity        = xt_rd[ADDR_W];
				res_d.sample_position = xt_rd[ADDR_W-1:0];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid)
					state_d = (q_item.op == OP_PUSH) ? ST_PUSH : ST_RD;
			end
			ST_PUSH:     state_d = smooth_q ? ST_SUM : ST_STORE;
			ST_SUM: begin
				if (k_q == n_q && !pend_q)
					state_d = ST_SDIV;
			end
			ST_SDIV: begin
				if (div_done)
					state_d = ST_STORE;
			end
			ST_STORE:    state_d = (LEN_W'(c_inc) >= len_eff) ? ST_MID : ST_IDLE;
			ST_MID:      state_d = ST_SW_RD;
			ST_SW_RD:    state_d = ST_SW_WT;
			ST_SW_WT:    state_d = (j_q != '0) ? ST_X_CHK : ST_NEXT;
			ST_X_CHK: begin
				if (rising || falling)
					state_d = ST_X_DIV;
				else
					state_d = (j_q >= ADDR_W'(2)) ? ST_P_CHK : ST_NEXT;
			end
			ST_X_DIV: begin
				if (div_done)
					state_d = (j_q >= ADDR_W'(2)) ? ST_P_CHK : ST_NEXT;
			end
			ST_P_CHK:    state_d = (is_max || is_min) ? ST_P_MUL : ST_NEXT;
			ST_P_MUL:    state_d = ST_P_DIV1;
			ST_P_DIV1: begin
				if (div_done)
					state_d = ST_P_START2;
			end
			ST_P_START2: state_d = ST_P_DIV2;
			ST_P_DIV2: begin
				if (div_done)
					state_d = ST_NEXT;
			end
			ST_NEXT:     state_d = (CNT_W'(j_q) + CNT_W'(1) < nrec_q) ? ST_SW_RD : ST_SUMMARY;
			ST_SUMMARY: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			ST_RD:       state_d = ST_RD_OUT;
			ST_RD_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop     = 1'b0;
		ring_we   = 1'b0;
		ring_re   = 1'b0;
		ring_ra   = c_q[RING_W-1:0] - k_q[RING_W-1:0];
		st_we     = 1'b0;
		st_re     = 1'b0;
		pt_we     = 1'b0;
		pt_re     = 1'b0;
		xt_we     = 1'b0;
		xt_re     = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		div_neg   = 1'b0;
		case (state_q)
			ST_IDLE:  q_pop = q_valid;
			ST_PUSH:  ring_we = 1'b1;
			ST_SUM: begin
				ring_re = k_q < n_q;
				if (k_q == n_q && !pend_q) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'({sum_mag, 8'b0});
					div_dvs   = DVS_W'(n_q);
					div_neg   = sum_q[SUM_W-1];
				end
			end
			ST_STORE: st_we = 1'b1;
			ST_SW_RD: st_re = 1'b1;
			ST_X_CHK: begin
				if (rising || falling) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'({x_num_m, 8'b0});
					div_dvs   = DVS_W'(x_den_m);
					div_neg   = x_num[VAL_W] ^ x_den[VAL_W];
				end
			end
			ST_X_DIV: xt_we = div_done;
			ST_P_MUL: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'({d_mag, 7'b0});
				div_dvs   = DVS_W'(den_mag);
				div_neg   = d_q[VAL_W] ^ den_q[VAL_W+1];
			end
			ST_P_START2: begin
				div_start = 1'b1;
				div_dvd   = dd_q;
				div_dvs   = DVS_W'({den_mag, 3'b0});
				div_neg   = den_q[VAL_W+1];
			end
			ST_P_DIV2: pt_we = div_done;
			ST_RD: begin
				pt_re = rd_hit && (item_q.op == OP_READ_PEAK);
				xt_re = rd_hit && (item_q.op != OP_READ_PEAK);
			end
			default: ;
		endcase
	end

	// datapath
	logic signed [2*VAL_W+1:0] dd_full;
	assign dd_full = d_q * d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rec_len_q   <= LEN_W'(MAX_RECORD);
			smooth_q    <= 1'b0;
			win_q       <= WCFG_W'(1);
			c_q         <= '0;
			pend_q      <= 1'b0;
			max_q       <= '0;
			min_q       <= '0;
			mid_q       <= '0;
			pcnt_q      <= '0;
			xcnt_q      <= '0;
			out_valid_q <= 1'b0;
			item_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			sum_q       <= '0;
			v_q         <= '0;
			nrec_q      <= '0;
			j_q         <= '0;
			ya_q        <= '0;
			yb_q        <= '0;
			yc_q        <= '0;
			xpol_q      <= 1'b0;
			ppol_q      <= 1'b0;
			rdv_q       <= 1'b0;
			div_neg_q   <= 1'b0;
			d_q         <= '0;
			den_q       <= '0;
			dd_q        <= '0;
			ppos_q      <= '0;
			res_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr.valid) begin
				case (cfg_reg_t'(cfg_wr.index))
					CFG_RECORD_LENGTH: rec_len_q <= cfg_wr.data;
					CFG_SMOOTHING_ON:  smooth_q  <= cfg_wr.data[0];
					CFG_WINDOW_LENGTH: win_q     <= cfg_wr.data[WCFG_W-1:0];
					default: ;
				endcase
			end
			if (div_start)
				div_neg_q <= div_neg;
			if ((state_q == ST_SUMMARY || state_q == ST_RD_OUT) && out_free) begin
				res_q       <= res_d;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_valid)
						item_q <= q_item;
				end
				ST_PUSH: begin
					n_q    <= n13[WIN_W-1:0];
					k_q    <= WIN_W'(1);
					pend_q <= 1'b0;
					sum_q  <= SUM_W'(item_q.sample);
					v_q    <= VAL_W'(item_q.sample) <<< 8;
				end
				ST_SUM: begin
					if (pend_q)
						sum_q <= sum_q + SUM_W'($signed(ring_rd));
					if (k_q < n_q) begin
						k_q    <= k_q + WIN_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				ST_SDIV: begin
					if (div_done)
						v_q <= sat24($signed(qs[VAL_W+1:0]));
				end
				ST_STORE: begin
					if (c_q == '0) begin
						max_q <= v_q;
						min_q <= v_q;
					end else begin
						if (v_q > max_q)
							max_q <= v_q;
						if (v_q < min_q)
							min_q <= v_q;
					end
					if (LEN_W'(c_inc) >= len_eff)
						nrec_q <= c_inc;
					else
						c_q <= c_inc[ADDR_W-1:0];
				end
				ST_MID: begin
					// halve toward zero
					mid_q  <= VAL_W'((mid_sum + (VAL_W+1)'(mid_sum[VAL_W])) >>> 1);
					pcnt_q <= '0;
					xcnt_q <= '0;
					j_q    <= '0;
					c_q    <= '0;
				end
				ST_SW_WT: begin
					ya_q <= yb_q;
					yb_q <= yc_q;
					yc_q <= $signed(st_rd);
				end
				ST_X_CHK: xpol_q <= rising;
				ST_X_DIV: begin
					if (div_done)
						xcnt_q <= xcnt_q + CNT_W'(1);
				end
				ST_P_CHK: begin
					d_q    <= d_now;
					den_q  <= den_now;
					ppol_q <= is_max;
				end
				ST_P_MUL: dd_q <= dd_full[DVD_W-1:0];
				ST_P_DIV1: begin
					if (div_done)
						ppos_q <= base_pos + qs[POS_W-1:0];
				end
				ST_P_DIV2: begin
					if (div_done)
						pcnt_q <= pcnt_q + CNT_W'(1);
				end
				ST_NEXT: j_q <= j_q + ADDR_W'(1);
				ST_RD: rdv_q <= rd_hit;
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

// ===== rtl/sine_peak_edge_detector_unit.sv =====
// Record analyser for sampled sine waves. Push samples (operation 0) until a
// record of record_length samples is complete; the block then finds strict
// local peaks (parabolic refinement) and midpoint crossings (linear
// refinement), fills both tables and returns one summary transaction. Reads
// (operations 1 and 2) return entries of the last completed record. A
// two-entry input queue decouples the port from the sequencer, and a result
// register holds the output transaction. With smoothing, a push first sums
// the active window (one ring read per cycle), then divides the sum on the
// serial divider. The push that closes a record adds a sweep over every
// stored sample, with one divide per crossing and two per peak, all on the
// shared serial divider.
module sine_peak_edge_detector_unit import sped_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [ADDR_W-1:0]             entry_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_kind,
	output logic                          entry_valid,
	output logic [POS_W-1:0]              position_q8,
	output logic signed [VAL_W-1:0]       level_q8,
	output logic                          polarity,
	output logic [ADDR_W-1:0]             sample_position,
	output logic [CNT_W-1:0]              peak_total,
	output logic [CNT_W-1:0]              crossing_total,
	output logic signed [VAL_W-1:0]       midpoint_q8,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [LEN_W-1:0]              cfg_data
);

	logic    q_valid, q_pop;
	item_t   q_item;
	res_t    res;
	cfg_wr_t cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

	sped_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .sample(sample), .entry_index(entry_index),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	sped_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_wr), .q_valid(q_valid),
		.q_item(q_item), .q_pop(q_pop), .out_valid(out_valid),
		.out_stall(out_stall), .out_res(res)
	);

	assign result_kind     = res.kind;
	assign entry_valid     = res.entry_valid;
	assign position_q8     = res.position;
	assign level_q8        = res.level;
	assign polarity        = res.polarity;
	assign sample_position = res.sample_position;
	assign peak_total      = res.peak_total;
	assign crossing_total  = res.crossing_total;
	assign midpoint_q8     = res.midpoint;

	a_summary_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_SUMMARY) |-> entry_valid)
		else $error("summary without entry_valid");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> (position_q8 == '0) && (level_q8 == '0)
			&& (sample_position == '0) && !polarity)
		else $error("missed read carries nonzero fields");

	a_entry_no_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != KIND_SUMMARY) |-> (peak_total == '0)
			&& (crossing_total == '0) && (midpoint_q8 == '0))
		else $error("table entry carries summary fields");

	a_cross_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_CROSS) |-> (level_q8 == '0))
		else $error("crossing entry with nonzero level");

endmodule

// ===== bench/testbench.sv =====
module testbench;
	import sped_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  RANDOM_ITEMS = 1100;
	localparam int  DRAIN_CYCLES = 500;
	localparam int  HOLD_CYCLES  = 3000;
	localparam int  LONG_RECORD  = 450;
	localparam longint CYCLE_LIMIT = 3_000_000;

	typedef struct {
		kind_t                    kind;
		bit                       entry_ok;
		bit [POS_W-1:0]           pos;
		bit signed [VAL_W-1:0]    level;
		bit                       pol;
		bit [ADDR_W-1:0]          idx;
		bit [CNT_W-1:0]           peaks;
		bit [CNT_W-1:0]           crossings;
		bit signed [VAL_W-1:0]    mid;
	} outcome_t;

	typedef struct {
		bit [POS_W-1:0]        pos;
		bit signed [VAL_W-1:0] level;
		bit                    pol;
		bit [ADDR_W-1:0]       idx;
	} table_entry_t;

	typedef struct {
		bit        is_cfg;
		bit [1:0]  code;
		int        value;
		int        index;
		bit        typed;
		outcome_t  want;
	} step_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    operation;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [ADDR_W-1:0]             entry_index;
	logic                          out_valid;
	logic                          out_stall;
	logic [1:0]                    result_kind;
	logic                          entry_valid;
	logic [POS_W-1:0]              position_q8;
	logic signed [VAL_W-1:0]       level_q8;
	logic                          polarity;
	logic [ADDR_W-1:0]             sample_position;
	logic [CNT_W-1:0]              peak_total;
	logic [CNT_W-1:0]              crossing_total;
	logic signed [VAL_W-1:0]       midpoint_q8;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index;
	logic [LEN_W-1:0]              cfg_data;

	sine_peak_edge_detector_unit DUT (.*);

	// predictor state
	int           smoothed[MAX_RECORD];
	int           window_ring[MAX_WINDOW];
	int unsigned  stored_count;
	int           max_level, min_level, mid_level;
	table_entry_t peak_tab[MAX_RECORD];
	table_entry_t cross_tab[MAX_RECORD];
	int unsigned  peak_cnt, cross_cnt;
	int unsigned  record_len_reg, smoothing_reg, window_reg;

	outcome_t pending_results[$];
	int       errors;
	int       items_sent, results_seen, records_closed, valid_reads;
	int       hold_left;
	bit       calm;
	longint   cycles;

	initial clk = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("FAIL sine_peak_edge_detector_unit");
			$finish;
		end
	end

	function automatic longint sat_q24(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	function automatic void reset_predictor();
		stored_count   = 0;
		max_level      = 0;
		min_level      = 0;
		mid_level      = 0;
		peak_cnt       = 0;
		cross_cnt      = 0;
		record_len_reg = 4096;
		smoothing_reg  = 0;
		window_reg     = 1;
	endfunction

	function automatic void analyze_record(int unsigned n);
		longint y1, y2, y3, d, den, pos, lev, mid;
		bit is_max, is_min, rising, falling;
		mid = (longint'(max_level) + longint'(min_level)) / 2;
		mid_level = int'(mid);
		peak_cnt  = 0;
		cross_cnt = 0;
		for (int unsigned i = 1; i + 1 < n; i++) begin
			y1 = smoothed[i-1];
			y2 = smoothed[i];
			y3 = smoothed[i+1];
			is_max = y2 > y1 && y2 > y3;
			is_min = y2 < y1 && y2 < y3;
			if (is_max || is_min) begin
				d   = y1 - y3;
				den = y1 - 2 * y2 + y3;
				pos = longint'(i) * 256 + (d * 128) / den;
				lev = y2 - (d * d) / (8 * den);
				peak_tab[peak_cnt].pos   = pos[POS_W-1:0];
				peak_tab[peak_cnt].level = sat_q24(lev);
				peak_tab[peak_cnt].pol   = is_max;
				peak_tab[peak_cnt].idx   = i;
				peak_cnt++;
			end
		end
		for (int unsigned i = 1; i < n; i++) begin
			y1 = smoothed[i-1];
			y2 = smoothed[i];
			rising  = y1 < mid && y2 >= mid;
			falling = y1 > mid && y2 <= mid;
			if (rising || falling) begin
				pos = longint'(i - 1) * 256 + ((mid - y1) * 256) / (y2 - y1);
				cross_tab[cross_cnt].pos   = pos[POS_W-1:0];
				cross_tab[cross_cnt].level = '0;
				cross_tab[cross_cnt].pol   = rising;
				cross_tab[cross_cnt].idx   = i - 1;
				cross_cnt++;
			end
		end
	endfunction

	// returns 1 when the item produces a result
	function automatic bit predict_item(op_t op, int s, int unsigned idx, output outcome_t r);
		int unsigned len, c, w, n;
		longint sum, v;
		table_entry_t e;
		r = '{kind: KIND_SUMMARY, default: 0};
		case (op)
			OP_PUSH: begin
				len = record_len_reg < 2 ? 2 : (record_len_reg > MAX_RECORD ? MAX_RECORD
					: record_len_reg);
				c = stored_count;
				window_ring[c % MAX_WINDOW] = s;
				if (smoothing_reg != 0) begin
					w = window_reg == 0 ? 1 : window_reg;
					if (w > len) w = len;
					if (w > MAX_WINDOW) w = MAX_WINDOW;
					n = c + 1 < w ? c + 1 : w;
					sum = 0;
					for (int unsigned k = 0; k < n; k++)
						sum += window_ring[(c - k) % MAX_WINDOW];
					v = (sum * 256) / longint'(n);
				end else begin
					v = longint'(s) * 256;
				end
				v = sat_q24(v);
				smoothed[c] = int'(v);
				if (c == 0 || v > max_level) max_level = int'(v);
				if (c == 0 || v < min_level) min_level = int'(v);
				stored_count = c + 1;
				if (stored_count < len)
					return 0;
				analyze_record(stored_count);
				stored_count = 0;
				r.entry_ok  = 1;
				r.peaks     = peak_cnt[CNT_W-1:0];
				r.crossings = cross_cnt[CNT_W-1:0];
				r.mid       = mid_level[VAL_W-1:0];
				return 1;
			end
			OP_READ_PEAK, OP_READ_CROSS: begin
				r.kind = op == OP_READ_PEAK ? KIND_PEAK : KIND_CROSS;
				if (idx < (op == OP_READ_PEAK ? peak_cnt : cross_cnt)) begin
					e = op == OP_READ_PEAK ? peak_tab[idx] : cross_tab[idx];
					r.entry_ok = 1;
					r.pos      = e.pos;
					r.level    = e.level;
					r.pol      = e.pol;
					r.idx      = e.idx;
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with nothing expected, kind %0d", $realtime,
					result_kind);
				errors++;
			end else begin
				w = pending_results.pop_front();
				check_field("result_kind", w.kind, result_kind);
				check_field("entry_valid", w.entry_ok, entry_valid);
				check_field("position_q8", w.pos, position_q8);
				check_field("level_q8", w.level, level_q8);
				check_field("polarity", w.pol, polarity);
				check_field("sample_position", w.idx, sample_position);
				check_field("peak_total", w.peaks, peak_total);
				check_field("crossing_total", w.crossings, crossing_total);
				check_field("midpoint_q8", w.mid, midpoint_q8);
			end
		end
	end

	// receiver: random stalls, long hold when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (calm) begin
			out_stall = 1'b0;
		end else begin
			out_stall = $urandom_range(99) < 25;
		end
	end

	task automatic send_item(op_t op, int s, int idx, bit typed, outcome_t want);
		outcome_t r;
		@(negedge clk);
		if (!calm && $urandom_range(99) < 25) begin
			in_valid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_valid    = 1'b1;
		operation   = op;
		sample      = s;
		entry_index = idx;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
		if (predict_item(op, s, idx, r)) begin
			if (r.kind == KIND_SUMMARY) records_closed++;
			if (r.kind != KIND_SUMMARY && r.entry_ok) valid_reads++;
			pending_results.push_back(typed ? want : r);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t which, int data);
		wait_drained();
		// let a push that produces nothing finish in the block
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = which;
		cfg_data  = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (which)
			CFG_RECORD_LENGTH: record_len_reg = data & 13'h1FFF;
			CFG_SMOOTHING_ON:  smoothing_reg  = data & 1;
			default:           window_reg     = data & 7'h7F;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int wave_sample(int k, real period, int amp, int noise);
		real v;
		v = amp * $sin(6.283185307 * k / period) + $urandom_range(2 * noise) - noise;
		if (v > 32767.0) v = 32767.0;
		if (v < -32768.0) v = -32768.0;
		return int'(v);
	endfunction

	outcome_t  none_out;
	step_row_t steps[$];

	function automatic outcome_t mk(kind_t k, bit ok, int pos, int pol, int idx,
		int pk, int cr, int mid);
		outcome_t o;
		o = '{kind: k, entry_ok: ok, pos: pos, level: 0, pol: pol, idx: idx,
			peaks: pk, crossings: cr, mid: mid};
		return o;
	endfunction

	initial begin
		int unsigned pick, style, n_items, phase, rand_items, amp, noise;
		real period;
		int s;
		outcome_t dummy;

		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_PUSH;
		sample = '0;
		entry_index = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RECORD_LENGTH;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		records_closed = 0;
		valid_reads = 0;
		hold_left = 0;
		calm = 1'b0;
		cycles = 0;
		none_out = '{kind: KIND_SUMMARY, default: 0};
		reset_predictor();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty tables, shortest record at full scale, clamps
		steps = '{
			'{0, OP_READ_PEAK,  0, 0,    1, mk(KIND_PEAK, 0, 0, 0, 0, 0, 0, 0)},
			'{0, OP_READ_CROSS, 0, 4095, 1, mk(KIND_CROSS, 0, 0, 0, 0, 0, 0, 0)},
			'{0, OP_NONE,       0, 7,    0, none_out},
			'{1, CFG_RECORD_LENGTH, 0, 0, 0, none_out},
			'{0, OP_PUSH,  32767,  0,    0, none_out},
			'{0, OP_PUSH, -32768,  0,    1, mk(KIND_SUMMARY, 1, 0, 0, 0, 0, 1, -128)},
			'{0, OP_READ_CROSS, 0, 0,    1, mk(KIND_CROSS, 1, 128, 0, 0, 0, 0, 0)},
			'{0, OP_READ_CROSS, 0, 1,    1, mk(KIND_CROSS, 0, 0, 0, 0, 0, 0, 0)},
			'{0, OP_READ_PEAK,  0, 0,    1, mk(KIND_PEAK, 0, 0, 0, 0, 0, 0, 0)},
			'{1, CFG_RECORD_LENGTH, 5, 0, 0, none_out},
			'{0, OP_PUSH, 0, 0, 0, none_out},
			'{0, OP_PUSH, 30000, 0, 0, none_out},
			'{0, OP_PUSH, -32768, 0, 0, none_out},
			'{0, OP_PUSH, 32767, 0, 0, none_out},
			'{0, OP_PUSH, 0, 0, 0, none_out},
			'{0, OP_READ_PEAK, 0, 1, 0, none_out},
			'{0, OP_READ_CROSS, 0, 2, 0, none_out},
			'{1, CFG_SMOOTHING_ON, 1, 0, 0, none_out},
			'{1, CFG_WINDOW_LENGTH, 127, 0, 0, none_out},
			'{1, CFG_RECORD_LENGTH, 3, 0, 0, none_out},
			'{0, OP_PUSH, -32768, 0, 0, none_out},
			'{0, OP_PUSH, 32767, 0, 0, none_out},
			'{0, OP_PUSH, -32768, 0, 0, none_out},
			'{1, CFG_WINDOW_LENGTH, 0, 0, 0, none_out},
			'{1, CFG_RECORD_LENGTH, 1, 0, 0, none_out}
		};
		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				write_reg(cfg_reg_t'(steps[i].code), steps[i].value);
			else
				send_item(op_t'(steps[i].code), steps[i].value, steps[i].index,
					steps[i].typed, steps[i].want);
		end

		// random phases: mostly noisy sine records, some raw and extreme data
		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			calm = phase >= 4 && phase < 7;
			pick = $urandom_range(99);
			write_reg(CFG_RECORD_LENGTH, pick < 80 ? $urandom_range(40, 2) :
				pick < 95 ? $urandom_range(300, 41) : $urandom_range(1));
			write_reg(CFG_SMOOTHING_ON, $urandom_range(1));
			pick = $urandom_range(9);
			write_reg(CFG_WINDOW_LENGTH, pick == 0 ? 0 : pick == 1 ? 64 : pick == 2 ? 127 :
				pick < 6 ? $urandom_range(8, 1) : $urandom_range(127));
			style  = $urandom_range(9);
			period = 4.0 + $urandom_range(40);
			amp    = $urandom_range(32767, 100);
			noise  = $urandom_range(3) == 0 ? 0 : $urandom_range(amp / 8);
			n_items = $urandom_range(120, 30);
			if (phase == 2) hold_left = HOLD_CYCLES;
			for (int k = 0; k < n_items; k++) begin
				pick = $urandom_range(99);
				if (phase == 9 && k == n_items / 2)
					wait_drained();
				if (pick < 3) begin
					send_item(OP_NONE, $urandom, $urandom, 0, dummy);
					continue;
				end
				rand_items++;
				if (pick < 22 || phase == 2)
					send_item($urandom_range(1) ? OP_READ_PEAK : OP_READ_CROSS, $urandom,
						$urandom_range(1) ? $urandom_range(15) : $urandom_range(4095), 0, dummy);
				else begin
					if (style < 7)
						s = wave_sample(k, period, amp, noise);
					else if (style < 9)
						s = $urandom_range(65535) - 32768;
					else
						s = $urandom_range(1) ? 32767 : -32768;
					send_item(OP_PUSH, s, $urandom, 0, dummy);
				end
			end
			phase++;
		end

		// one long record, then reads from its tables
		calm = 1'b0;
		write_reg(CFG_SMOOTHING_ON, 0);
		write_reg(CFG_RECORD_LENGTH, LONG_RECORD);
		for (int k = 0; k < LONG_RECORD; k++)
			send_item(OP_PUSH, wave_sample(k, 256.0, 30000, 0), 0, 0, dummy);
		for (int k = 0; k < 20; k++)
			send_item($urandom_range(1) ? OP_READ_PEAK : OP_READ_CROSS, 0,
				$urandom_range(40), 0, dummy);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items over %0d random phases; %0d results checked,", items_sent,
			phase, results_seen);
		$display("%0d records analyzed, %0d table entries read back", records_closed,
			valid_reads);
		if (errors == 0)
			$display("PASS sine_peak_edge_detector_unit");
		else
			$display("FAIL sine_peak_edge_detector_unit");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sped_pkg.sv
rtl/sped_ram.sv
rtl/sped_div.sv
rtl/sped_front.sv
rtl/sped_back.sv
rtl/sine_peak_edge_detector_unit.sv
bench/testbench.sv
